[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// clocked assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising clk edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/zsbe_pkg.sv]
// ----------------------------------------------------------------------------
// zsbe_pkg
// shared types and constants of the zlib stored block encoder
// ----------------------------------------------------------------------------
package zsbe_pkg;

  localparam logic [7:0]  HDR_CMF   = 8'h78;
  localparam logic [7:0]  HDR_FLG   = 8'h01;
  localparam logic [15:0] MAX_BLOCK = 16'hFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one classified item: what the back part has to emit for it
  typedef struct packed {
    logic [7:0]  data;
    logic        hdr;
    logic        blk;
    logic        final_blk;
    logic        last;
    logic [15:0] len;
    logic [15:0] sum_high;
    logic [15:0] sum_low;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [11:0] {
    S_HDR0 = 12'b0000_0000_0001,
    S_HDR1 = 12'b0000_0000_0010,
    S_BLK0 = 12'b0000_0000_0100,
    S_BLK1 = 12'b0000_0000_1000,
    S_BLK2 = 12'b0000_0001_0000,
    S_BLK3 = 12'b0000_0010_0000,
    S_BLK4 = 12'b0000_0100_0000,
    S_DATA = 12'b0000_1000_0000,
    S_ADL0 = 12'b0001_0000_0000,
    S_ADL1 = 12'b0010_0000_0000,
    S_ADL2 = 12'b0100_0000_0000,
    S_ADL3 = 12'b1000_0000_0000
  } step_t;

endpackage

[hw/rtl/zlib_stored_block_encoder.sv]
// ----------------------------------------------------------------------------
// zlib_stored_block_encoder
// wraps a raw byte stream into a zlib stream of stored deflate blocks
// ----------------------------------------------------------------------------
// input side: an item (data_byte) is taken when push is high and full is low
// output side: out_byte, last_of_run and stream_done are valid while empty is
// low; the item is taken when pop is high and empty is low
// cfg_wen writes stream_length; the value is sampled when a stream starts
// the front part takes one byte per cycle while full is low, classifies it
// and updates adler-32; the back part sends one output byte per cycle from
// a 4-entry queue while the queue is not empty and pop is high or the output
// register is empty; an input byte yields 1 output byte, plus 2 at stream
// start, 5 at a block start and 4 at stream end; the back part sets throughput
// an item's output bytes pass its queue entry, then the output register
// when pop stays low the output register holds, the queue fills and full rises
// after reset: no stream under way, stored stream length is 1, adler restarted
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zlib_stored_block_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [23:0] stream_length,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        stream_done
);
  import zsbe_pkg::*;

  cmd_t      new_cmd;
  cmd_t      head_cmd;
  q_status_t q_status;
  logic      accept;
  logic      q_rd;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  zsbe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .stream_length (stream_length),
    .accept        (accept),
    .data_byte     (data_byte),
    .cmd           (new_cmd)
  );

  zsbe_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept),
    .wr_cmd (new_cmd),
    .rd     (q_rd),
    .rd_cmd (head_cmd),
    .status (q_status)
  );

  zsbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_status.empty),
    .head        (head_cmd),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .stream_done (stream_done)
  );

  `ASSERT_CLK(a_done_is_last, !empty |-> (!stream_done || last_of_run), "stream_done without last_of_run")
  `ASSERT_CLK(a_queue_sane, !(q_status.full && q_status.empty), "queue both full and empty")
  `ASSERT_CLK(a_accept_queued, accept |=> !q_status.empty, "accepted item not queued")

endmodule

[hw/rtl/zsbe_front.sv]
// ----------------------------------------------------------------------------
// zsbe_front
// accepts raw bytes, tracks stream and block position, runs adler-32
// ----------------------------------------------------------------------------
module zsbe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wen,
  input  logic [23:0]   stream_length,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  output zsbe_pkg::cmd_t cmd
);
  import zsbe_pkg::*;

  logic [23:0] length_reg;
  logic [23:0] bytes_left;
  logic [15:0] block_left;
  logic [15:0] sum_low;
  logic [15:0] sum_high;

  logic        start;
  logic [23:0] bl;
  logic        blk;
  logic [15:0] len;
  logic [15:0] cur_block;
  logic        last;
  logic [16:0] low_add;
  logic [15:0] low_next;
  logic [16:0] high_add;
  logic [15:0] high_next;

  always_comb begin
    start     = (bytes_left == 24'd0);
    bl        = start ? ((length_reg == 24'd0) ? 24'd1 : length_reg) : bytes_left;
    blk       = start || (block_left == 16'd0);
    len       = (bl > {8'd0, MAX_BLOCK}) ? MAX_BLOCK : bl[15:0];
    cur_block = blk ? len : block_left;
    last      = (bl == 24'd1);
    low_add   = {1'b0, sum_low} + {9'd0, data_byte};
    low_next  = (low_add >= ADLER_MOD) ? 16'(low_add - ADLER_MOD) : low_add[15:0];
    high_add  = {1'b0, sum_high} + {1'b0, low_next};
    high_next = (high_add >= ADLER_MOD) ? 16'(high_add - ADLER_MOD) : high_add[15:0];

    cmd.data      = data_byte;
    cmd.hdr       = start;
    cmd.blk       = blk;
    cmd.final_blk = (bl <= {8'd0, MAX_BLOCK});
    cmd.last      = last;
    cmd.len       = len;
    cmd.sum_high  = high_next;
    cmd.sum_low   = low_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg <= 24'd1;
    end else if (cfg_wen) begin
      length_reg <= stream_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 24'd0;
      block_left <= 16'd0;
      sum_low    <= 16'd1;
      sum_high   <= 16'd0;
    end else if (accept) begin
      bytes_left <= bl - 24'd1;
      if (last) begin
        block_left <= 16'd0;
        sum_low    <= 16'd1;
        sum_high   <= 16'd0;
      end else begin
        block_left <= cur_block - 16'd1;
        sum_low    <= low_next;
        sum_high   <= high_next;
      end
    end
  end

endmodule

[hw/rtl/zsbe_queue.sv]
// ----------------------------------------------------------------------------
// zsbe_queue
// short command queue between front and back parts
// ----------------------------------------------------------------------------
module zsbe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  zsbe_pkg::cmd_t      wr_cmd,
  input  logic                rd,
  output zsbe_pkg::cmd_t      rd_cmd,
  output zsbe_pkg::q_status_t status
);
  import zsbe_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign status.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign rd_cmd       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/zsbe_back.sv]
// ----------------------------------------------------------------------------
// zsbe_back
// expands each command into zlib bytes, one byte per cycle while emit is high
// ----------------------------------------------------------------------------
module zsbe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  zsbe_pkg::cmd_t head,
  output logic           q_rd,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           last_of_run,
  output logic           stream_done
);
  import zsbe_pkg::*;

  step_t step;
  step_t step_next;
  step_t cur_step;
  logic  fresh;
  logic  out_valid;
  logic  emit;
  logic  is_end;
  logic [7:0] byte_sel;

  always_comb begin
    if (fresh) begin
      priority if (head.hdr) begin
        cur_step = S_HDR0;
      end else if (head.blk) begin
        cur_step = S_BLK0;
      end else begin
        cur_step = S_DATA;
      end
    end else begin
      cur_step = step;
    end
  end

  always_comb begin
    step_next = S_DATA;
    is_end    = 1'b0;
    byte_sel  = head.data;
    unique case (cur_step)
      S_HDR0: begin
        byte_sel  = HDR_CMF;
        step_next = S_HDR1;
      end
      S_HDR1: begin
        byte_sel  = HDR_FLG;
        step_next = head.blk ? S_BLK0 : S_DATA;
      end
      S_BLK0: begin
        byte_sel  = {7'd0, head.final_blk};
        step_next = S_BLK1;
      end
      S_BLK1: begin
        byte_sel  = head.len[7:0];
        step_next = S_BLK2;
      end
      S_BLK2: begin
        byte_sel  = head.len[15:8];
        step_next = S_BLK3;
      end
      S_BLK3: begin
        byte_sel  = ~head.len[7:0];
        step_next = S_BLK4;
      end
      S_BLK4: begin
        byte_sel  = ~head.len[15:8];
        step_next = S_DATA;
      end
      S_DATA: begin
        byte_sel  = head.data;
        step_next = S_ADL0;
        is_end    = !head.last;
      end
      S_ADL0: begin
        byte_sel  = head.sum_high[15:8];
        step_next = S_ADL1;
      end
      S_ADL1: begin
        byte_sel  = head.sum_high[7:0];
        step_next = S_ADL2;
      end
      S_ADL2: begin
        byte_sel  = head.sum_low[15:8];
        step_next = S_ADL3;
      end
      S_ADL3: begin
        byte_sel  = head.sum_low[7:0];
        step_next = S_HDR0;
        is_end    = 1'b1;
      end
      default: begin
        byte_sel  = head.data;
        step_next = S_DATA;
        is_end    = 1'b1;
      end
    endcase
  end

  assign emit  = !q_empty && (!out_valid || pop);
  assign q_rd  = emit && is_end;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh     <= 1'b1;
      step      <= S_DATA;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        fresh <= is_end;
        step  <= step_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= byte_sel;
      last_of_run <= is_end;
      stream_done <= (cur_step == S_ADL3);
    end
  end

endmodule
